FILE: rtl/tbu_pkg.sv
// tbu_pkg: shared types and constants for the terminal byte utf8 classifier
// used by tbu_decode, tbu_out_buf and terminal_byte_utf8_classifier_unit
package tbu_pkg;

  typedef enum logic [2:0] {
    EK_ECHO    = 3'd0,
    EK_CODE    = 3'd1,
    EK_ESC     = 3'd2,
    EK_INVALID = 3'd3,
    EK_UNKNOWN = 3'd4
  } event_kind_e;

  localparam int unsigned ValueW = 31;
  localparam int unsigned CntW   = 3;

  localparam logic [7:0] ByteBel    = 8'h07;
  localparam logic [7:0] ByteBs     = 8'h08;
  localparam logic [7:0] ByteWsLast = 8'h0D;
  localparam logic [7:0] ByteEsc    = 8'h1B;
  localparam logic [7:0] BytePrFirst = 8'h20;
  localparam logic [7:0] BytePrLast  = 8'h7E;
  localparam logic [7:0] Lead6 = 8'b1111_1100;
  localparam logic [7:0] Lead5 = 8'b1111_1000;
  localparam logic [7:0] Lead4 = 8'b1111_0000;
  localparam logic [7:0] Lead3 = 8'b1110_0000;
  localparam logic [7:0] Lead2 = 8'b1100_0000;
  localparam logic [7:0] ContMark = 8'b1000_0000;
  localparam logic [7:0] ContBits = 8'b0011_1111;

  typedef struct packed {
    event_kind_e         kind;
    logic [ValueW-1:0]   value;
    logic                last;
  } result_t;

  typedef struct packed {
    logic [CntW-1:0]   remaining;
    logic [ValueW-1:0] acc;
    logic [CntW-1:0]   taken;
  } seq_state_t;

  // results produced by one item, slot 0 first
  typedef struct packed {
    logic [1:0] n;
    result_t    r1;
    result_t    r0;
  } load_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic       room;
  } buf_status_t;

endpackage

FILE: rtl/terminal_byte_utf8_classifier_unit.sv
// terminal_byte_utf8_classifier_unit: top level, input register, sequence state, result buffer
// depends on tbu_pkg, tbu_decode, tbu_out_buf
//
//  channel | handshake              | payload
//  in      | in_valid_i, in_ready_o | in_byte_i
//  out     | out_valid_o,out_ready_i| event_kind_o, event_value_o, last_of_run_o
//
// a byte is held in the input register, then is decoded into the result
// buffer, which drives the output channel
// one byte per cycle while each byte yields at most one result and out_ready_i is
// high; a byte with two results holds the input register while the buffer drains
// reset clears the input register, the sequence state and the result buffer
// a stalled output backs up into the input register and then drops in_ready_o
module terminal_byte_utf8_classifier_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_kind_o,
  output logic [30:0] event_value_o,
  output logic        last_of_run_o
);

  logic                 vld_q;
  logic [7:0]           byte_q;
  logic                 move;
  tbu_pkg::seq_state_t  st_q, st_d;
  tbu_pkg::load_t       load;
  tbu_pkg::result_t     res;
  tbu_pkg::buf_status_t status;

  assign move       = vld_q && status.room;
  assign in_ready_o = !vld_q || move;

  tbu_decode u_decode (
    .byte_i  (byte_q),
    .state_i (st_q),
    .state_o (st_d),
    .load_o  (load)
  );

  tbu_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (move),
    .load_data_i (load),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (res),
    .status_o    (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      st_q  <= '0;
    end else begin
      if (in_ready_o) begin
        vld_q <= in_valid_i;
      end
      if (move) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

  assign event_kind_o  = res.kind;
  assign event_value_o = res.value;
  assign last_of_run_o = res.last;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.cnt != 2'd3)
    else $error("result buffer count out of range");

  a_head_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.cnt == 2'd2 |-> !last_of_run_o)
    else $error("first of two results flagged last");

  a_seq_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.remaining != 3'd0 |-> ({1'b0, st_q.remaining} + {1'b0, st_q.taken}) == 4'd6 ||
      ({1'b0, st_q.remaining} + {1'b0, st_q.taken}) < 4'd6)
    else $error("sequence length exceeds six bytes");

  a_no_load_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.cnt == 2'd2 |-> !move)
    else $error("item loaded into full result buffer");

endmodule

FILE: rtl/tbu_decode.sv
// tbu_decode: one-pass classification of a byte against the open sequence state
// depends on tbu_pkg
module tbu_decode (
  input  logic [7:0]          byte_i,
  input  tbu_pkg::seq_state_t state_i,
  output tbu_pkg::seq_state_t state_o,
  output tbu_pkg::load_t      load_o
);

  logic                          seq_open;
  logic                          is_cont;
  logic [tbu_pkg::ValueW-1:0]    acc_shift;
  tbu_pkg::result_t              fresh_res;
  logic                          fresh_has;
  tbu_pkg::seq_state_t           fresh_state;
  tbu_pkg::result_t              inv_res;

  assign seq_open  = (state_i.remaining != '0);
  assign is_cont   = ((byte_i & ~tbu_pkg::ContBits) == tbu_pkg::ContMark);
  assign acc_shift = {state_i.acc[tbu_pkg::ValueW-7:0], byte_i[5:0]};

  // handling of a byte with no sequence open
  always_comb begin
    fresh_res.kind  = tbu_pkg::EK_UNKNOWN;
    fresh_res.value = {{(tbu_pkg::ValueW-8){1'b0}}, byte_i};
    fresh_res.last  = 1'b1;
    fresh_has       = 1'b1;
    fresh_state     = '0;
    if ((byte_i >= tbu_pkg::BytePrFirst && byte_i <= tbu_pkg::BytePrLast) ||
        (byte_i >= tbu_pkg::ByteBs && byte_i <= tbu_pkg::ByteWsLast)) begin
      fresh_res.kind = tbu_pkg::EK_ECHO;
    end else if (byte_i == tbu_pkg::ByteBel) begin
      fresh_has = 1'b0;
    end else if (byte_i == tbu_pkg::ByteEsc) begin
      fresh_res.kind = tbu_pkg::EK_ESC;
    end else if (byte_i >= tbu_pkg::Lead2) begin
      fresh_has         = 1'b0;
      fresh_state.taken = 3'd1;
      if (byte_i >= tbu_pkg::Lead6) begin
        fresh_state.remaining = 3'd5;
        fresh_state.acc       = {{(tbu_pkg::ValueW-1){1'b0}}, byte_i[0]};
      end else if (byte_i >= tbu_pkg::Lead5) begin
        fresh_state.remaining = 3'd4;
        fresh_state.acc       = {{(tbu_pkg::ValueW-2){1'b0}}, byte_i[1:0]};
      end else if (byte_i >= tbu_pkg::Lead4) begin
        fresh_state.remaining = 3'd3;
        fresh_state.acc       = {{(tbu_pkg::ValueW-3){1'b0}}, byte_i[2:0]};
      end else if (byte_i >= tbu_pkg::Lead3) begin
        fresh_state.remaining = 3'd2;
        fresh_state.acc       = {{(tbu_pkg::ValueW-4){1'b0}}, byte_i[3:0]};
      end else begin
        fresh_state.remaining = 3'd1;
        fresh_state.acc       = {{(tbu_pkg::ValueW-5){1'b0}}, byte_i[4:0]};
      end
    end
  end

  always_comb begin
    inv_res.kind  = tbu_pkg::EK_INVALID;
    inv_res.value = {{(tbu_pkg::ValueW-tbu_pkg::CntW){1'b0}}, state_i.taken};
    inv_res.last  = ~fresh_has;
  end

  always_comb begin
    state_o   = fresh_state;
    load_o    = '0;
    if (seq_open && is_cont) begin
      if (state_i.remaining == 3'd1) begin
        // final continuation byte closes the code point
        state_o         = '0;
        load_o.n        = 2'd1;
        load_o.r0.kind  = tbu_pkg::EK_CODE;
        load_o.r0.value = acc_shift;
        load_o.r0.last  = 1'b1;
      end else begin
        state_o.remaining = state_i.remaining - 3'd1;
        state_o.acc       = acc_shift;
        state_o.taken     = state_i.taken + 3'd1;
      end
    end else if (seq_open) begin
      // broken sequence: report it, then treat the byte as fresh
      load_o.r0 = inv_res;
      load_o.r1 = fresh_res;
      load_o.n  = fresh_has ? 2'd2 : 2'd1;
    end else begin
      load_o.r0 = fresh_res;
      load_o.n  = fresh_has ? 2'd1 : 2'd0;
    end
  end

endmodule

FILE: rtl/tbu_out_buf.sv
// tbu_out_buf: two-slot result register feeding the output channel
// depends on tbu_pkg
module tbu_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  tbu_pkg::load_t       load_data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output tbu_pkg::result_t     res_o,
  output tbu_pkg::buf_status_t status_o
);

  tbu_pkg::result_t s0_q, s0_d, s1_q, s1_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             pop;

  assign out_valid_o   = (cnt_q != 2'd0);
  assign pop           = out_valid_o && out_ready_i;
  assign res_o         = s0_q;
  // room for a whole item's results once the current head leaves
  assign status_o.room = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready_i);
  assign status_o.cnt  = cnt_q;

  always_comb begin
    s0_d  = s0_q;
    s1_d  = s1_q;
    cnt_d = cnt_q;
    if (load_i) begin
      s0_d  = load_data_i.r0;
      s1_d  = load_data_i.r1;
      cnt_d = load_data_i.n;
    end else if (pop) begin
      s0_d  = s1_q;
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

endmodule

FILE: sim/tbu_event_checker.sv
// tbu_event_checker: watches both channels of the terminal byte classifier,
// predicts the events of every accepted byte and compares them in order
// depends on tbu_pkg for the event kinds, byte constants and result_t
module tbu_event_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  event_kind_i,
  input  logic [30:0] event_value_i,
  input  logic        last_of_run_i,
  output int unsigned err_count_o,
  output int unsigned pending_o,
  output int unsigned events_checked_o,
  output int unsigned code_points_o
);
  timeunit 1ns;
  timeprecision 1ps;

  tbu_pkg::result_t expected_events[$];
  tbu_pkg::result_t got_want;
  logic [2:0]       seq_left;
  logic [2:0]       seq_taken;
  logic [30:0]      seq_acc;
  int unsigned      errs;
  int unsigned      checked;
  int unsigned      codes;

  task automatic add_event(input tbu_pkg::event_kind_e kind, input logic [30:0] value);
    tbu_pkg::result_t r;
    r.kind  = kind;
    r.value = value;
    r.last  = 1'b0;
    expected_events.push_back(r);
  endtask

  // byte seen with no sequence open
  task automatic take_fresh(input logic [7:0] b);
    logic [2:0] len;
    if ((b >= tbu_pkg::BytePrFirst && b <= tbu_pkg::BytePrLast) ||
        (b >= tbu_pkg::ByteBs && b <= tbu_pkg::ByteWsLast)) begin
      add_event(tbu_pkg::EK_ECHO, 31'(b));
    end else if (b == tbu_pkg::ByteBel) begin
      // bell is swallowed
    end else if (b == tbu_pkg::ByteEsc) begin
      add_event(tbu_pkg::EK_ESC, 31'(tbu_pkg::ByteEsc));
    end else if (b >= tbu_pkg::Lead2) begin
      if (b >= tbu_pkg::Lead6) begin
        len = 3'd6; seq_acc = 31'(b & 8'h01);
      end else if (b >= tbu_pkg::Lead5) begin
        len = 3'd5; seq_acc = 31'(b & 8'h03);
      end else if (b >= tbu_pkg::Lead4) begin
        len = 3'd4; seq_acc = 31'(b & 8'h07);
      end else if (b >= tbu_pkg::Lead3) begin
        len = 3'd3; seq_acc = 31'(b & 8'h0F);
      end else begin
        len = 3'd2; seq_acc = 31'(b & 8'h1F);
      end
      seq_left  = len - 3'd1;
      seq_taken = 3'd1;
    end else begin
      add_event(tbu_pkg::EK_UNKNOWN, 31'(b));
    end
  endtask

  task automatic predict_events(input logic [7:0] b);
    int unsigned base;
    tbu_pkg::result_t r;
    base = expected_events.size();
    if (seq_left != 3'd0) begin
      if (b >= tbu_pkg::ContMark && b < tbu_pkg::Lead2) begin
        seq_acc   = {seq_acc[24:0], b[5:0] & tbu_pkg::ContBits[5:0]};
        seq_taken = seq_taken + 3'd1;
        seq_left  = seq_left - 3'd1;
        if (seq_left == 3'd0) begin
          add_event(tbu_pkg::EK_CODE, seq_acc);
          seq_acc   = '0;
          seq_taken = '0;
        end
      end else begin
        // broken sequence: report it, then the byte starts over
        add_event(tbu_pkg::EK_INVALID, 31'(seq_taken));
        seq_left  = '0;
        seq_acc   = '0;
        seq_taken = '0;
        take_fresh(b);
      end
    end else begin
      take_fresh(b);
    end
    if (expected_events.size() > base) begin
      r = expected_events.pop_back();
      r.last = 1'b1;
      expected_events.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_events.delete();
      seq_left  = '0;
      seq_taken = '0;
      seq_acc   = '0;
      errs      = 0;
      checked   = 0;
      codes     = 0;
      err_count_o      <= 0;
      pending_o        <= 0;
      events_checked_o <= 0;
      code_points_o    <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        predict_events(in_byte_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_events.size() == 0) begin
          $error("unexpected result: event_kind %0d event_value 0x%0h last_of_run %0b",
                 event_kind_i, event_value_i, last_of_run_i);
          errs++;
        end else begin
          got_want = expected_events.pop_front();
          if (event_kind_i !== got_want.kind) begin
            $error("event_kind expected %0d actual %0d", got_want.kind, event_kind_i);
            errs++;
          end
          if (event_value_i !== got_want.value) begin
            $error("event_value expected 0x%0h actual 0x%0h", got_want.value, event_value_i);
            errs++;
          end
          if (last_of_run_i !== got_want.last) begin
            $error("last_of_run expected %0b actual %0b", got_want.last, last_of_run_i);
            errs++;
          end
          checked++;
          if (got_want.kind == tbu_pkg::EK_CODE) codes++;
        end
      end
      err_count_o      <= errs;
      pending_o        <= expected_events.size();
      events_checked_o <= checked;
      code_points_o    <= codes;
    end
  end

endmodule

FILE: sim/terminal_byte_utf8_classifier_unit_tb.sv
// terminal_byte_utf8_classifier_unit_tb: clock, reset and byte stimulus for the classifier
// under four idle/stall mixes; depends on tbu_pkg, the rtl and tbu_event_checker
module terminal_byte_utf8_classifier_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PhaseBytes    = 425;
  localparam int unsigned HoldCycles    = 120;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned TailCycles    = 8;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i   = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  event_kind_o;
  logic [30:0] event_value_o;
  logic        last_of_run_o;

  int unsigned err_count;
  int unsigned pending_events;
  int unsigned events_checked;
  int unsigned code_points;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bytes_sent     = 0;
  logic        hold_req       = 1'b0;

  int unsigned send_idle_tbl[4]  = '{0, 45, 0, 7};
  int unsigned recv_stall_tbl[4] = '{0, 0, 45, 7};

  // extremes, each byte class, and broken sequences ending in a printable byte, bell, a new lead and esc
  logic [7:0] directed_bytes[$] = '{
    8'h00, 8'h07, 8'h08, 8'h0D, 8'h1B, 8'h20, 8'h7E, 8'h7F, 8'h80,
    8'hC3, 8'hA9,
    8'hFF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
    8'hC0, 8'h41,
    8'hE0, 8'h80, 8'h07,
    8'hF8, 8'hC5, 8'h1B
  };

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  terminal_byte_utf8_classifier_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_kind_o  (event_kind_o),
    .event_value_o (event_value_o),
    .last_of_run_o (last_of_run_o)
  );

  tbu_event_checker u_event_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_byte_i        (in_byte_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_kind_i     (event_kind_o),
    .event_value_i    (event_value_o),
    .last_of_run_i    (last_of_run_o),
    .err_count_o      (err_count),
    .pending_o        (pending_events),
    .events_checked_o (events_checked),
    .code_points_o    (code_points)
  );

  // returns at the edge where the byte is taken
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_random_chunk();
    int unsigned pick;
    int unsigned len;
    int unsigned keep;
    int unsigned k;
    logic [7:0] lead;
    pick = $urandom_range(99);
    if (pick < 55 || (pick >= 70 && pick < 80)) begin
      len = $urandom_range(6, 2);
      case (len)
        2: lead = tbu_pkg::Lead2 | 8'($urandom_range(31));
        3: lead = tbu_pkg::Lead3 | 8'($urandom_range(15));
        4: lead = tbu_pkg::Lead4 | 8'($urandom_range(7));
        5: lead = tbu_pkg::Lead5 | 8'($urandom_range(3));
        default: lead = tbu_pkg::Lead6 | 8'($urandom_range(3));
      endcase
      send_byte(lead);
      // well formed runs all continuations, a broken one stops short and then sends a random byte
      keep = (pick < 55) ? len - 1 : $urandom_range(len - 2);
      for (k = 0; k < keep; k++) send_byte(tbu_pkg::ContMark | 8'($urandom_range(63)));
      if (pick >= 55) send_byte(8'($urandom_range(255)));
    end else if (pick < 70) begin
      if ($urandom_range(3) == 0) send_byte(8'($urandom_range(13, 8)));
      else send_byte(8'($urandom_range(126, 32)));
    end else if (pick < 88) begin
      case ($urandom_range(4))
        0: send_byte(tbu_pkg::ByteBel);
        1: send_byte(tbu_pkg::ByteEsc);
        2: send_byte(8'h7F);
        3: send_byte(8'($urandom_range(31)));
        default: send_byte(8'($urandom_range(191, 128)));
      endcase
    end else begin
      send_byte(8'($urandom_range(255)));
    end
  endtask

  // output side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned ph;
    int unsigned phase_end;
    logic        hold_done;
    hold_done = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_idle_tbl[ph];
      recv_stall_pct = recv_stall_tbl[ph];
      if (ph == 0) begin
        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
      end
      phase_end = bytes_sent + PhaseBytes;
      while (bytes_sent < phase_end) begin
        send_random_chunk();
        // sender keeps offering while the output is held off
        if (ph == 0 && !hold_done && bytes_sent + 300 >= phase_end) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
      end
      // pause until every event of this phase is out
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (pending_events != 0);
    end
    repeat (TailCycles) @(posedge clk_i);
    $display("fed %0d bytes through four idle/stall mixes and one long output hold-off",
             bytes_sent);
    $display("checked %0d events, %0d of them decoded code points", events_checked,
             code_points);
    if (err_count == 0 && pending_events == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
